FILE: hw/rtl/start_stop_byte_frame_sync_defines.svh
// Assertion macros shared by the frame sync RTL.
// No dependencies; included by files that carry assertions.
`ifndef START_STOP_BYTE_FRAME_SYNC_DEFINES_SVH
`define START_STOP_BYTE_FRAME_SYNC_DEFINES_SVH

// same-cycle implication, off during reset
`define SSBFS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define SSBFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/ssbfs_pkg.sv
// Types and constants for the start/stop byte frame sync.
// No dependencies; imported by ssbfs_chain and the top level.
package ssbfs_pkg;

  localparam logic [7:0] STOP_BYTE  = 8'd107;
  localparam logic [7:0] START_BYTE = 8'd1;
  localparam int         LEN_W      = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT
  } ssbfs_state_t;

  // control of the byte chain: move every cell one place, cell 0 takes rx or wraps
  typedef struct packed {
    logic shift;
    logic load_rx;
  } ssbfs_chain_ctl_t;

endpackage

FILE: hw/rtl/ssbfs_cell.sv
// One byte cell of the window chain.
// Depends on nothing; instantiated by ssbfs_chain.
module ssbfs_cell (
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] din,
  output logic [7:0] dout
);

  logic [7:0] data_r;

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= din;
    end
  end

  assign dout = data_r;

endmodule

FILE: hw/rtl/ssbfs_chain.sv
// Row of byte cells holding the receive window, newest byte in cell 0.
// Depends on ssbfs_pkg and ssbfs_cell.
module ssbfs_chain #(
  parameter int WINDOW_DEPTH = 32
) (
  input  logic                              clk,
  input  ssbfs_pkg::ssbfs_chain_ctl_t       ctl,
  input  logic [7:0]                        rx_byte,
  input  logic [$clog2(WINDOW_DEPTH)-1:0]   rd_idx,
  output logic [7:0]                        rd_byte
);
  import ssbfs_pkg::*;

  logic [7:0] cell_q [WINDOW_DEPTH];
  logic [7:0] cell_d [WINDOW_DEPTH];

  // cell 0 takes the new byte, or the oldest cell when the row rotates out a frame
  assign cell_d[0] = ctl.load_rx ? rx_byte : cell_q[WINDOW_DEPTH-1];

  genvar i;
  generate
    for (i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      if (i > 0) begin : g_link
        assign cell_d[i] = cell_q[i-1];
      end
      ssbfs_cell u_cell (
        .clk  (clk),
        .en   (ctl.shift),
        .din  (cell_d[i]),
        .dout (cell_q[i])
      );
    end
  endgenerate

  assign rd_byte = cell_q[rd_idx];

endmodule

FILE: hw/rtl/start_stop_byte_frame_sync.sv
// Top level of the start/stop byte frame sync: control, count and output stage.
// Depends on ssbfs_pkg, ssbfs_chain and start_stop_byte_frame_sync_defines.svh.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | sink      | in_valid/in_stall  | in_rx_byte
//  out     | source    | out_valid/out_stall| out_frame_byte, out_frame_size, out_frame_last
//  cfg     | sink      | cfg_valid/cfg_ready| cfg_fixed_length
//
// Each accepted byte enters the chain, then is tested for a frame end in ST_CHECK.
// A frame of n bytes then streams out one beat per cycle while out is not stalled,
// the chain rotating one place per beat past a fixed read tap.
// A stall on out holds the output register and pauses the rotation.
// Synchronous reset clears the held count, the fixed length, the state and the output valid; cell
// contents are not reset.
`include "start_stop_byte_frame_sync_defines.svh"

module start_stop_byte_frame_sync #(
  parameter int WINDOW_DEPTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_frame_byte,
  output logic [ssbfs_pkg::LEN_W-1:0] out_frame_size,
  output logic                        out_frame_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ssbfs_pkg::LEN_W-1:0] cfg_fixed_length
);
  import ssbfs_pkg::*;

  localparam int IW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int LW = (CW > LEN_W) ? CW : LEN_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);

  ssbfs_state_t       state_r, state_nxt;
  logic [LEN_W-1:0]   fixed_len_r;
  logic [CW-1:0]      held_r, held_nxt;
  logic               stop_r;
  logic [LW-1:0]      len_r;
  logic [IW-1:0]      cnt_r;
  logic               out_valid_r;
  logic [7:0]         out_byte_r;
  logic [LEN_W-1:0]   out_size_r;
  logic               out_last_r;

  logic               in_accept;
  logic               emit_go;
  logic               frame_hit;
  logic               emit_last;
  logic [LW-1:0]      cand_len;
  logic [LW-1:0]      len_m1;
  logic [IW-1:0]      rd_idx;
  logic [7:0]         rd_byte;
  ssbfs_chain_ctl_t   chain_ctl;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;

  // frame length if this stop byte closes a frame
  assign cand_len = (fixed_len_r == '0) ? LW'(held_r) : LW'(fixed_len_r);
  assign len_m1   = ((state_r == ST_CHECK) ? cand_len : len_r) - LW'(1);
  assign rd_idx   = len_m1[IW-1:0];

  assign frame_hit = stop_r &&
                     ((fixed_len_r == '0) ||
                      ((cand_len <= LW'(held_r)) && (rd_byte == START_BYTE)));
  assign emit_last = (cnt_r == rd_idx);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = frame_hit ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (emit_go && emit_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall          = 1'b1;
    emit_go           = 1'b0;
    case (state_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_CHECK: in_stall = 1'b1;
      ST_EMIT:  emit_go  = !out_valid_r || !out_stall;
      default:  in_stall = 1'b1;
    endcase
    chain_ctl.shift   = in_accept || emit_go;
    chain_ctl.load_rx = in_accept;
  end

  always_comb begin
    held_nxt = held_r;
    if (in_accept && (held_r != DEPTH_C)) begin
      held_nxt = held_r + CW'(1);
    end else if ((state_r == ST_CHECK) && frame_hit) begin
      held_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= '0;
      fixed_len_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      if (cfg_valid && cfg_ready) fixed_len_r <= cfg_fixed_length;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) stop_r <= (in_rx_byte == STOP_BYTE);
    if (state_r == ST_CHECK) begin
      len_r <= cand_len;
      cnt_r <= '0;
    end else if (emit_go) begin
      cnt_r <= cnt_r + IW'(1);
    end
    if (emit_go) begin
      out_byte_r <= rd_byte;
      out_size_r <= len_r[LEN_W-1:0];
      out_last_r <= emit_last;
    end
  end

  ssbfs_chain #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_chain (
    .clk     (clk),
    .ctl     (chain_ctl),
    .rx_byte (in_rx_byte),
    .rd_idx  (rd_idx),
    .rd_byte (rd_byte)
  );

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_frame_size = out_size_r;
  assign out_frame_last = out_last_r;

  `SSBFS_ASSERT_SAME(a_held_bound, 1'b1, held_r <= DEPTH_C, "held count beyond window depth")
  `SSBFS_ASSERT_SAME(a_rise_from_emit, $rose(out_valid_r), $past(state_r) == ST_EMIT, "out beat not from emit")
  `SSBFS_ASSERT_NEXT(a_accept_check, in_accept, (state_r == ST_CHECK) && (held_r != '0), "accepted beat not tested")
  `SSBFS_ASSERT_NEXT(a_frame_end, emit_go && emit_last, (state_r == ST_IDLE) && out_frame_last, "frame end not closed")

endmodule
